### src/mpra_pkg.sv
// ============================================================================
// mpra_pkg
// Shared types and constants for the multi-pool resource allocator.
// ============================================================================
package mpra_pkg;

    localparam int SLOT_MAX      = 3;
    localparam int POOL_NUM      = 4;
    localparam int FREE_W        = $clog2(SLOT_MAX + 1);
    localparam int WANT_W        = 2;
    localparam int IN_PID_W      = 10;

    localparam int PRINTER_COUNT = 2;
    localparam int SCANNER_COUNT = 1;
    localparam int MODEM_COUNT   = 1;
    localparam int DRIVE_COUNT   = 2;
    localparam int PID_BITS      = 10;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef struct packed {
        logic                func;
        logic [IN_PID_W-1:0] pid;
        logic                real_time;
        logic [WANT_W-1:0]   want_printers;
        logic [WANT_W-1:0]   want_scanners;
        logic [WANT_W-1:0]   want_modems;
        logic [WANT_W-1:0]   want_drives;
    } req_t;

    typedef struct packed {
        logic              granted;
        logic [FREE_W-1:0] free_printers;
        logic [FREE_W-1:0] free_scanners;
        logic [FREE_W-1:0] free_modems;
        logic [FREE_W-1:0] free_drives;
    } rsp_t;

    typedef struct packed {
        logic              take;
        logic              drop;
        logic [WANT_W-1:0] want;
    } pool_cmd_t;

    typedef struct packed {
        logic              fits;
        logic [FREE_W-1:0] free_next;
    } pool_stat_t;

endpackage

### src/mpra_pool.sv
// ============================================================================
// mpra_pool
// One device pool: slot ownership, free count, first-fit take, release by pid.
// ============================================================================
module mpra_pool #(
    parameter int COUNT    = mpra_pkg::PRINTER_COUNT,
    parameter int PID_BITS = mpra_pkg::PID_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  mpra_pkg::pool_cmd_t   cmd,
    input  logic [PID_BITS-1:0]   pid,
    output mpra_pkg::pool_stat_t  stat
);

    logic [COUNT-1:0]    busy_reg;
    logic [COUNT-1:0]    busy_next;
    logic [PID_BITS-1:0] owner_reg  [COUNT];
    logic [PID_BITS-1:0] owner_next [COUNT];

    logic [mpra_pkg::FREE_W-1:0] free_cur;
    logic [mpra_pkg::FREE_W-1:0] free_new;
    logic [mpra_pkg::WANT_W-1:0] got;

    always_comb
    begin
        free_cur = '0;
        for (int i = 0; i < COUNT; i++)
        begin
            free_cur = free_cur + {{(mpra_pkg::FREE_W-1){1'b0}}, ~busy_reg[i]};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        got       = '0;
        for (int i = 0; i < COUNT; i++)
        begin
            owner_next[i] = owner_reg[i];
        end
        if (cmd.drop)
        begin
            for (int i = 0; i < COUNT; i++)
            begin
                if (busy_reg[i] && owner_reg[i] == pid)
                begin
                    busy_next[i] = 1'b0;
                end
            end
        end
        else if (cmd.take)
        begin
            for (int i = 0; i < COUNT; i++)
            begin
                if (!busy_reg[i] && got < cmd.want)
                begin
                    busy_next[i]  = 1'b1;
                    owner_next[i] = pid;
                    got           = got + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        free_new = '0;
        for (int i = 0; i < COUNT; i++)
        begin
            free_new = free_new + {{(mpra_pkg::FREE_W-1){1'b0}}, ~busy_next[i]};
        end
    end

    assign stat.fits      = cmd.want <= free_cur;
    assign stat.free_next = step ? free_new : free_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if (step)
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < COUNT; i++)
            begin
                owner_reg[i] <= owner_next[i];
            end
        end
    end

endmodule

### src/multi_pool_resource_allocator_core.sv
// ============================================================================
// multi_pool_resource_allocator_core
// Four device pools with all-or-nothing allocation and release by pid.
// ============================================================================
// A transaction is taken on every cycle with start high; busy never rises.
// Each transaction produces one result on rsp with done high, once it has
// passed the input register and then the pool check and update into the
// result register. Results cannot be held off, so the receiver must take
// done whenever it is high.
module multi_pool_resource_allocator_core #(
    parameter int PRINTER_COUNT = mpra_pkg::PRINTER_COUNT,
    parameter int SCANNER_COUNT = mpra_pkg::SCANNER_COUNT,
    parameter int MODEM_COUNT   = mpra_pkg::MODEM_COUNT,
    parameter int DRIVE_COUNT   = mpra_pkg::DRIVE_COUNT,
    parameter int PID_BITS      = mpra_pkg::PID_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mpra_pkg::req_t req,
    output logic           done,
    output mpra_pkg::rsp_t rsp
);

    localparam int IPW = mpra_pkg::IN_PID_W;

    logic           in_vld_reg;
    mpra_pkg::req_t in_reg;
    logic           res_vld_reg;
    mpra_pkg::rsp_t res_reg;
    mpra_pkg::rsp_t res_next;

    logic [PID_BITS-1:0]    pid_eff;
    logic                   alloc;
    logic                   all_fit;
    mpra_pkg::pool_cmd_t    cmd   [mpra_pkg::POOL_NUM];
    mpra_pkg::pool_stat_t   stat  [mpra_pkg::POOL_NUM];
    logic [mpra_pkg::WANT_W-1:0] want [mpra_pkg::POOL_NUM];

    assign busy = 1'b0;

    generate
        if (PID_BITS > IPW)
        begin : g_pid_wide
            assign pid_eff = {{(PID_BITS-IPW){1'b0}}, in_reg.pid};
        end
        else if (PID_BITS == IPW)
        begin : g_pid_eq
            assign pid_eff = in_reg.pid;
        end
        else
        begin : g_pid_narrow
            assign pid_eff = in_reg.pid[PID_BITS-1:0];
        end
    endgenerate

    assign want[0] = in_reg.want_printers;
    assign want[1] = in_reg.want_scanners;
    assign want[2] = in_reg.want_modems;
    assign want[3] = in_reg.want_drives;

    assign alloc   = in_reg.func == mpra_pkg::FUNC_ALLOC;
    assign all_fit = stat[0].fits && stat[1].fits && stat[2].fits && stat[3].fits;

    always_comb
    begin
        for (int k = 0; k < mpra_pkg::POOL_NUM; k++)
        begin
            cmd[k].want = want[k];
            cmd[k].drop = in_reg.func == mpra_pkg::FUNC_RELEASE;
            cmd[k].take = alloc && !in_reg.real_time && all_fit;
        end
    end

    mpra_pool #(.COUNT(PRINTER_COUNT), .PID_BITS(PID_BITS)) u_printers (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_vld_reg),
        .cmd   (cmd[0]),
        .pid   (pid_eff),
        .stat  (stat[0])
    );

    mpra_pool #(.COUNT(SCANNER_COUNT), .PID_BITS(PID_BITS)) u_scanners (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_vld_reg),
        .cmd   (cmd[1]),
        .pid   (pid_eff),
        .stat  (stat[1])
    );

    mpra_pool #(.COUNT(MODEM_COUNT), .PID_BITS(PID_BITS)) u_modems (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_vld_reg),
        .cmd   (cmd[2]),
        .pid   (pid_eff),
        .stat  (stat[2])
    );

    mpra_pool #(.COUNT(DRIVE_COUNT), .PID_BITS(PID_BITS)) u_drives (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_vld_reg),
        .cmd   (cmd[3]),
        .pid   (pid_eff),
        .stat  (stat[3])
    );

    always_comb
    begin
        res_next.granted       = !alloc || in_reg.real_time || all_fit;
        res_next.free_printers = stat[0].free_next;
        res_next.free_scanners = stat[1].free_next;
        res_next.free_modems   = stat[2].free_next;
        res_next.free_drives   = stat[3].free_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= start && !busy;
            res_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= req;
        end
        if (in_vld_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign done = res_vld_reg;
    assign rsp  = res_reg;

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg |=> done)
        else $error("result strobe missing after a stage transaction");

    a_refuse_alloc_only: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !res_next.granted |-> alloc && !in_reg.real_time)
        else $error("refusal on a release or real-time transaction");

    a_refuse_keeps_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !res_next.granted |=>
            rsp.free_printers == $past(stat[0].free_next)
            && rsp.free_drives == $past(stat[3].free_next)
            && !$past(cmd[0].take))
        else $error("refused transaction changed a pool");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.free_printers <= PRINTER_COUNT && rsp.free_scanners <= SCANNER_COUNT
            && rsp.free_modems <= MODEM_COUNT && rsp.free_drives <= DRIVE_COUNT)
        else $error("free count above pool size");

endmodule
